[rtl/core/tlu_pkg.sv]
// shared widths and default sizes for the euclidean tour length unit
`timescale 1ns / 1ps

package tlu_pkg;

  localparam int INDEX_BITS = 9;
  localparam int IN_COORD_BITS = 16;
  localparam int SUM_BITS = 34;
  localparam int SEG_BITS = 9;

  localparam int IN_DATA_BITS = 48;
  localparam int OUT_DATA_BITS = 48;

  localparam int DEF_MAX_POINTS = 512;
  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TOUR = 1'b1;

endpackage

[rtl/core/tlu_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps

module tlu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/euclidean_tour_length_unit.sv]
// top level of the euclidean tour length unit
//
//  channel   dir  fields
//  s_axis    in   tuser: cmd; tdata: index, x_coord, y_coord; tlast: last
//  m_axis    out  tdata: total_length, segment_count
//
// a load request is written to the point ram as it is accepted; a later tour city
// reads the point ram twice, then steps through diff, square, radicand, the
// bit-serial square root, one root bit per cycle, and accumulate
// the first city of a tour only records its index; a final city then goes to emit
// rst is synchronous and clears the tour state; the point ram is not cleared
// a result waiting on m_axis stalls only the emit of the next result

`timescale 1ns / 1ps

module euclidean_tour_length_unit #(
  parameter int MAX_POINTS = tlu_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = tlu_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = tlu_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // index[8:0], x_coord[24:9], y_coord[40:25], zero pad
  input  logic [tlu_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                       s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // total_length[33:0], segment_count[42:34], zero pad
  output logic [tlu_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  import tlu_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int IXW = ((AW > INDEX_BITS) ? AW : INDEX_BITS) + 1;
  localparam int XW  = (COORD_BITS > IN_COORD_BITS) ? COORD_BITS : IN_COORD_BITS;
  localparam int SQW = 2 * COORD_BITS;
  localparam int RW  = COORD_BITS + 1 + FRAC_BITS;
  localparam int SW  = 2 * RW;
  localparam int CW  = $clog2(RW);
  localparam int TW  = ((SUM_BITS > RW) ? SUM_BITS : RW) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDCUR = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_RAD   = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;

  // request fields
  logic [INDEX_BITS-1:0]    in_index;
  logic [IN_COORD_BITS-1:0] in_x;
  logic [IN_COORD_BITS-1:0] in_y;
  logic                     in_cmd;
  logic                     in_accept;
  logic [XW-1:0]            x_wide;
  logic [XW-1:0]            y_wide;

  // tour state
  logic [INDEX_BITS-1:0] prev_city;
  logic                  tour_started;
  logic [SUM_BITS-1:0]   len_sum;
  logic [SEG_BITS-1:0]   segs;

  // per-city work registers
  logic [INDEX_BITS-1:0] cur_idx;
  logic                  cur_last;
  logic                  prev_ok;
  logic                  cur_ok;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SQW-1:0]        sqx;
  logic [SQW-1:0]        sqy;
  logic [SW-1:0]         rad;
  logic [RW+1:0]         rem;
  logic [RW-1:0]         root;
  logic [CW-1:0]         cnt;

  // ram port
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [2*COORD_BITS-1:0]   ram_wdata;
  logic [2*COORD_BITS-1:0]   ram_rdata;
  logic [COORD_BITS-1:0]     rd_x;
  logic [COORD_BITS-1:0]     rd_y;

  logic [IXW-1:0] in_wide;
  logic [IXW-1:0] prev_wide;
  logic [IXW-1:0] cur_wide;
  logic           in_ok;
  logic           prev_city_ok;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;
  logic [SQW:0]  sq_sum;
  logic [TW-1:0] sum_wide;
  logic          out_free;
  logic [SUM_BITS-1:0] out_len;
  logic [SEG_BITS-1:0] out_seg;

  assign in_index = s_axis_tdata[INDEX_BITS-1:0];
  assign in_x     = s_axis_tdata[INDEX_BITS +: IN_COORD_BITS];
  assign in_y     = s_axis_tdata[INDEX_BITS+IN_COORD_BITS +: IN_COORD_BITS];
  assign in_cmd   = s_axis_tuser[0];

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign x_wide = XW'(in_x);
  assign y_wide = XW'(in_y);

  assign in_wide      = IXW'(in_index);
  assign prev_wide    = IXW'(prev_city);
  assign cur_wide     = IXW'(cur_idx);
  assign in_ok        = in_wide < IXW'(MAX_POINTS);
  assign prev_city_ok = prev_wide < IXW'(MAX_POINTS);

  assign ram_we    = in_accept && (in_cmd == CMD_LOAD) && in_ok;
  assign ram_wdata = {y_wide[COORD_BITS-1:0], x_wide[COORD_BITS-1:0]};
  assign rd_x      = ram_rdata[COORD_BITS-1:0];
  assign rd_y      = ram_rdata[2*COORD_BITS-1:COORD_BITS];

  always_comb begin
    unique case (state)
      S_RDCUR: ram_addr = cur_wide[AW-1:0];
      S_IDLE:  ram_addr = ram_we ? in_wide[AW-1:0] : prev_wide[AW-1:0];
      default: ram_addr = prev_wide[AW-1:0];
    endcase
  end

  tlu_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // one root bit per step
  assign rem_sh = {rem[RW-1:0], rad[SW-1:SW-2]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  assign sq_sum   = (SQW+1)'(sqx) + (SQW+1)'(sqy);
  assign sum_wide = TW'(len_sum) + TW'(root);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_city     <= '0;
      tour_started  <= 1'b0;
      len_sum       <= '0;
      segs          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (in_cmd == CMD_TOUR)) begin
            cur_idx  <= in_index;
            cur_last <= s_axis_tlast;
            cur_ok   <= in_ok;
            prev_ok  <= prev_city_ok;
            if (tour_started) begin
              state <= S_RDCUR;
            end else begin
              tour_started <= 1'b1;
              prev_city    <= in_index;
              if (s_axis_tlast) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_RDCUR: begin
          ax    <= prev_ok ? rd_x : '0;
          ay    <= prev_ok ? rd_y : '0;
          state <= S_DIFF;
        end
        S_DIFF: begin
          if (cur_ok) begin
            dx <= (ax >= rd_x) ? ax - rd_x : rd_x - ax;
            dy <= (ay >= rd_y) ? ay - rd_y : rd_y - ay;
          end else begin
            dx <= ax;
            dy <= ay;
          end
          state <= S_SQ;
        end
        S_SQ: begin
          sqx   <= SQW'(dx) * SQW'(dx);
          sqy   <= SQW'(dy) * SQW'(dy);
          state <= S_RAD;
        end
        S_RAD: begin
          rad   <= SW'(sq_sum) << (2 * FRAC_BITS);
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rad  <= rad << 2;
          rem  <= take ? rem_sh - trial : rem_sh;
          root <= {root[RW-2:0], take};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(RW - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (sum_wide > TW'({SUM_BITS{1'b1}})) begin
            len_sum <= '1;
          end else begin
            len_sum <= sum_wide[SUM_BITS-1:0];
          end
          if (segs != '1) begin
            segs <= segs + 1'b1;
          end
          prev_city <= cur_idx;
          state     <= cur_last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            tour_started  <= 1'b0;
            prev_city     <= '0;
            len_sum       <= '0;
            segs          <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_len <= len_sum;
      out_seg <= segs;
    end
  end

  assign m_axis_tdata = OUT_DATA_BITS'({out_seg, out_len});

`ifndef SYNTH
  a_root_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> (cnt <= CW'(RW - 1)))
    else $error("root step count out of range");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free) |=>
      (!tour_started && (len_sum == '0) && (segs == '0) && m_axis_tvalid))
    else $error("tour state not cleared on emit");

  a_tour_reads: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_cmd == CMD_TOUR) && tour_started) |=> (state == S_RDCUR))
    else $error("tour city did not start a segment");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && !out_free) |=> (state == S_EMIT))
    else $error("result dropped while output busy");
`endif

endmodule

[test/tlu_checker.sv]
// checker for the tour length unit: predicts tour results from accepted requests and compares
`timescale 1ns / 1ps

module tour_length_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // index[8:0], x_coord[24:9], y_coord[40:25], zero pad
  input  logic [tlu_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                       s_axis_tuser,
  input  logic                             s_axis_tlast,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // total_length[33:0], segment_count[42:34], zero pad
  input  logic [tlu_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output int                               errors,
  output int                               pending
);

  import tlu_pkg::*;

  localparam longint unsigned LENGTH_CAP = (64'd1 << SUM_BITS) - 64'd1;
  localparam logic [SEG_BITS-1:0] SEG_CAP = '1;

  typedef struct packed {
    logic [SUM_BITS-1:0] length;
    logic [SEG_BITS-1:0] segs;
  } tour_result_t;

  tour_result_t tour_results_due[$];

  logic [IN_COORD_BITS-1:0] city_x [DEF_MAX_POINTS];
  logic [IN_COORD_BITS-1:0] city_y [DEF_MAX_POINTS];
  logic [INDEX_BITS-1:0]    prev_city;
  bit                       in_tour;
  logic [SUM_BITS-1:0]      length_acc;
  logic [SEG_BITS-1:0]      segs_acc;

  initial begin
    errors = 0;
    pending = 0;
  end

  // floor of the square root, one result bit per step
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 48;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned leg_length(logic [INDEX_BITS-1:0] a,
                                                 logic [INDEX_BITS-1:0] b);
    longint unsigned dx;
    longint unsigned dy;
    dx = (city_x[a] > city_x[b]) ? 64'(city_x[a] - city_x[b]) : 64'(city_x[b] - city_x[a]);
    dy = (city_y[a] > city_y[b]) ? 64'(city_y[a] - city_y[b]) : 64'(city_y[b] - city_y[a]);
    return floor_root((dx * dx + dy * dy) << (2 * DEF_FRAC_BITS));
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic take_request(input logic cmd, input logic [INDEX_BITS-1:0] idx,
                              input logic [IN_COORD_BITS-1:0] x,
                              input logic [IN_COORD_BITS-1:0] y, input logic last);
    longint unsigned leg;
    if (cmd == CMD_LOAD) begin
      city_x[idx] = x;
      city_y[idx] = y;
    end else begin
      if (in_tour) begin
        leg = leg_length(prev_city, idx);
        if (leg > LENGTH_CAP - length_acc) begin
          length_acc = LENGTH_CAP[SUM_BITS-1:0];
        end else begin
          length_acc = length_acc + leg[SUM_BITS-1:0];
        end
        if (segs_acc != SEG_CAP) begin
          segs_acc = segs_acc + 1'b1;
        end
      end
      in_tour = 1'b1;
      prev_city = idx;
      if (last) begin
        tour_results_due.push_back('{length: length_acc, segs: segs_acc});
        in_tour = 1'b0;
        prev_city = '0;
        length_acc = '0;
        segs_acc = '0;
      end
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_BITS-1:0] data);
    tour_result_t due;
    if (tour_results_due.size() == 0) begin
      report($sformatf("result %h with no tour pending", data));
    end else begin
      due = tour_results_due.pop_front();
      if (data[SUM_BITS-1:0] !== due.length) begin
        report($sformatf("total_length %0d, predicted %0d", data[SUM_BITS-1:0], due.length));
      end
      if (data[SUM_BITS+SEG_BITS-1:SUM_BITS] !== due.segs) begin
        report($sformatf("segment_count %0d, predicted %0d",
                         data[SUM_BITS+SEG_BITS-1:SUM_BITS], due.segs));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prev_city = '0;
      in_tour = 1'b0;
      length_acc = '0;
      segs_acc = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_request(s_axis_tuser[0], s_axis_tdata[8:0], s_axis_tdata[24:9],
                     s_axis_tdata[40:25], s_axis_tlast);
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
    end
    pending <= tour_results_due.size();
  end

endmodule

[test/testbench.sv]
// stimulus and verdict for the euclidean tour length unit
`timescale 1ns / 1ps

module testbench;

  import tlu_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1140;
  localparam int LONG_TOUR_CITIES = 740;
  localparam int LATENCY_PAD = 64;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic [0:0]               s_axis_tuser = '0;
  logic                     s_axis_tlast = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int          errors;
  int          pending;
  int          cycles = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          rx_hold = 0;
  int unsigned rx_roll;
  int          items_sent = 0;
  bit          loaded [DEF_MAX_POINTS];
  int          loaded_slots[$];

  euclidean_tour_length_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tour_length_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      end
    end
  end

  function automatic int gap_len();
    int roll;
    if (tx_steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_COORD_BITS-1:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      return '0;
    end else if (roll < 4) begin
      return '1;
    end
    return IN_COORD_BITS'($urandom);
  endfunction

  function automatic logic [INDEX_BITS-1:0] any_loaded();
    return INDEX_BITS'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
  endfunction

  task automatic send(input logic cmd, input logic [INDEX_BITS-1:0] idx,
                      input logic [IN_COORD_BITS-1:0] x, input logic [IN_COORD_BITS-1:0] y,
                      input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {7'b0, y, x, idx};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_point(input logic [INDEX_BITS-1:0] idx, input logic [IN_COORD_BITS-1:0] x,
                            input logic [IN_COORD_BITS-1:0] y, input logic last);
    send(CMD_LOAD, idx, x, y, last);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_slots.push_back(int'(idx));
    end
  endtask

  // coordinates on a tour request are noise
  task automatic visit(input logic [INDEX_BITS-1:0] idx, input logic last);
    send(CMD_TOUR, idx, IN_COORD_BITS'($urandom), IN_COORD_BITS'($urandom), last);
  endtask

  task automatic random_tour(input int cities);
    for (int i = 0; i < cities; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        load_point(INDEX_BITS'($urandom_range(0, DEF_MAX_POINTS - 1)), pick_coord(),
                   pick_coord(), 1'($urandom_range(0, 1)));
      end
      visit(any_loaded(), i == cities - 1);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int roll;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // corners of the plane and two inner points, last flag on a load
    load_point(9'd0, 16'h0000, 16'h0000, 1'b0);
    load_point(9'd511, 16'hFFFF, 16'hFFFF, 1'b1);
    load_point(9'd1, 16'hFFFF, 16'h0000, 1'b0);
    load_point(9'd2, 16'h0000, 16'hFFFF, 1'b0);
    load_point(9'd3, 16'h5555, 16'hAAAA, 1'b0);
    load_point(9'd256, 16'hAAAA, 16'h5555, 1'b0);
    // one-city tour, longest leg, zero leg
    visit(9'd0, 1'b1);
    visit(9'd0, 1'b0);
    visit(9'd511, 1'b1);
    visit(9'd1, 1'b0);
    visit(9'd2, 1'b1);
    visit(9'd3, 1'b0);
    visit(9'd3, 1'b1);
    // loads in the middle of a tour, one rewriting the current city
    visit(9'd1, 1'b0);
    load_point(9'd3, 16'h1234, 16'h8765, 1'b1);
    visit(9'd3, 1'b0);
    load_point(9'd3, 16'hFEDC, 16'h0123, 1'b0);
    visit(9'd256, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_steady = ph[0];
      rx_steady <= ph[1];
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          load_point(INDEX_BITS'($urandom_range(0, DEF_MAX_POINTS - 1)), pick_coord(),
                     pick_coord(), 1'($urandom_range(0, 1)));
        end else if (roll < 80) begin
          random_tour($urandom_range(1, 8));
        end else if (roll < 97) begin
          random_tour($urandom_range(9, 30));
        end else begin
          random_tour($urandom_range(31, 100));
        end
      end
      drain();
    end

    // long tour between opposite corners saturates both counters
    tx_steady = 1'b1;
    rx_steady <= 1'b0;
    load_point(9'd0, 16'h0000, 16'h0000, 1'b0);
    load_point(9'd511, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int i = 0; i < LONG_TOUR_CITIES; i++) begin
      visit((i % 2 == 1) ? 9'd511 : 9'd0, i == LONG_TOUR_CITIES - 1);
    end
    drain();

    repeat (LATENCY_PAD) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tlu_pkg.sv
rtl/core/tlu_ram.sv
rtl/core/euclidean_tour_length_unit.sv
test/tlu_checker.sv
test/testbench.sv
